// ===== hw/rtl/hhsp_pkg.sv =====
package hhsp_pkg;

  // width of the body byte counter
  localparam int COUNT_WIDTH = 16;
  localparam int TOK_W       = 16;
  localparam int LEN_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // result event codes
  localparam logic [1:0] EV_DATA      = 2'd0;
  localparam logic [1:0] EV_TOKEN_END = 2'd1;
  localparam logic [1:0] EV_HDR_END   = 2'd2;

  // sections
  localparam logic [2:0] SEC_METHOD  = 3'd0;
  localparam logic [2:0] SEC_STATUS  = 3'd1;
  localparam logic [2:0] SEC_PATH    = 3'd2;
  localparam logic [2:0] SEC_VERSION = 3'd3;
  localparam logic [2:0] SEC_KEY     = 3'd4;
  localparam logic [2:0] SEC_VALUE   = 3'd5;
  localparam logic [2:0] SEC_LENGTH  = 3'd6;
  localparam logic [2:0] SEC_BODY    = 3'd7;

  // message kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_GET     = 2'd1;
  localparam logic [1:0] KIND_OTHER   = 2'd2;
  localparam logic [1:0] KIND_REPLY   = 2'd3;

  // input request types
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [TOK_W-1:0] MAX_TOKEN_RESET = TOK_W'(200);

  localparam logic [3:0] REPLY_LEN = 4'd5;
  localparam logic [3:0] GET_LEN   = 4'd3;
  localparam logic [3:0] CLEN_LEN  = 4'd14;
  localparam logic [3:0] MPOS_MAX  = 4'd15;

  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

  typedef struct packed {
    logic [1:0]       ev;
    logic [2:0]       section;
    logic [7:0]       data;
    logic [1:0]       kind;
    logic             is_len;
    logic [LEN_W-1:0] clen;
    logic             trunc;
    logic             last;
  } res_t;

  // "HTTP/"
  function automatic logic [7:0] reply_char(input logic [3:0] pos);
    unique case (pos)
      4'd0:    reply_char = 8'h48;
      4'd1:    reply_char = 8'h54;
      4'd2:    reply_char = 8'h54;
      4'd3:    reply_char = 8'h50;
      4'd4:    reply_char = 8'h2F;
      default: reply_char = 8'h00;
    endcase
  endfunction

  // "GET"
  function automatic logic [7:0] get_char(input logic [3:0] pos);
    unique case (pos)
      4'd0:    get_char = 8'h47;
      4'd1:    get_char = 8'h45;
      4'd2:    get_char = 8'h54;
      default: get_char = 8'h00;
    endcase
  endfunction

  // "Content-Length"
  function automatic logic [7:0] clen_char(input logic [3:0] pos);
    unique case (pos)
      4'd0:    clen_char = 8'h43;
      4'd1:    clen_char = 8'h6F;
      4'd2:    clen_char = 8'h6E;
      4'd3:    clen_char = 8'h74;
      4'd4:    clen_char = 8'h65;
      4'd5:    clen_char = 8'h6E;
      4'd6:    clen_char = 8'h74;
      4'd7:    clen_char = 8'h2D;
      4'd8:    clen_char = 8'h4C;
      4'd9:    clen_char = 8'h65;
      4'd10:   clen_char = 8'h6E;
      4'd11:   clen_char = 8'h67;
      4'd12:   clen_char = 8'h74;
      4'd13:   clen_char = 8'h68;
      default: clen_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== hw/rtl/hhsp_core.sv =====
module hhsp_core
  import hhsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_req,
  input  logic [7:0]       in_byte,
  output logic             in_ready,
  input  logic             cfg_valid,
  input  logic [TOK_W-1:0] cfg_data,
  input  logic             slot_free,
  output logic             res_valid,
  output res_t             res
);

  typedef enum logic [3:0] {
    PH_METHOD, PH_STATUS, PH_PATH, PH_VERSION, PH_KEY, PH_LEN_SEP, PH_LEN,
    PH_HDR_SEP, PH_HDR_VAL, PH_LINE_START, PH_BODY_SEP, PH_BODY
  } phase_t;

  logic             in_valid_r;
  logic             in_req_r;
  logic [7:0]       in_byte_r;
  logic [TOK_W-1:0] max_len_r;

  phase_t           phase_r, phase_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [TOK_W-1:0] tc_r, tc_nxt;
  logic [3:0]       mpos_r, mpos_nxt, mpos_upd;
  logic [2:0]       mflags_r, mflags_nxt, mflags_upd;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic             done_r, done_nxt;
  count_t           body_r, body_nxt;
  logic             drop_r, drop_nxt;

  logic             adv;
  logic [7:0]       c;
  logic             room;
  logic             do_store, do_end, do_digit, end_islen, fin;
  logic [2:0]       sec;
  logic [19:0]      acc_mul;
  logic             emit;
  logic [1:0]       ev;
  logic [2:0]       ev_sec;
  logic [7:0]       ev_byte;
  logic             ev_islen, ev_trunc, ev_last;

  assign adv      = in_valid_r && slot_free;
  assign in_ready = !in_valid_r || adv;
  assign c        = in_byte_r;
  assign room     = tc_r < max_len_r;
  assign acc_mul  = {4'b0, acc_r} * 20'd10 + {12'b0, c - CH_0};

  always_comb begin
    mflags_upd = mflags_r;
    if (mpos_r < REPLY_LEN && c != reply_char(mpos_r)) mflags_upd[0] = 1'b0;
    if (mpos_r >= GET_LEN || c != get_char(mpos_r))    mflags_upd[1] = 1'b0;
    if (mpos_r >= CLEN_LEN || c != clen_char(mpos_r))  mflags_upd[2] = 1'b0;
    mpos_upd = (mpos_r < MPOS_MAX) ? mpos_r + 4'd1 : MPOS_MAX;
  end

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    tc_nxt     = tc_r;
    mpos_nxt   = mpos_r;
    mflags_nxt = mflags_r;
    acc_nxt    = acc_r;
    done_nxt   = done_r;
    body_nxt   = body_r;
    drop_nxt   = drop_r;
    do_store   = 1'b0;
    do_end     = 1'b0;
    do_digit   = 1'b0;
    end_islen  = 1'b0;
    sec        = SEC_METHOD;
    fin        = 1'b0;
    emit       = 1'b0;
    ev         = EV_DATA;
    ev_sec     = SEC_METHOD;
    ev_byte    = 8'h00;
    ev_islen   = 1'b0;
    ev_trunc   = 1'b0;
    ev_last    = 1'b0;

    if (in_req_r == REQ_CLOSE) begin
      phase_nxt = PH_METHOD;
      kind_nxt  = KIND_UNKNOWN;
      acc_nxt   = '0;
      done_nxt  = 1'b0;
      body_nxt  = '0;
      tc_nxt     = '0;
      drop_nxt   = 1'b0;
      mpos_nxt   = '0;
      mflags_nxt = 3'b111;
    end else if (c != CH_CR) begin
      unique case (phase_r)
        PH_METHOD: begin
          sec = SEC_METHOD;
          if (c != CH_SP) begin
            do_store = 1'b1;
          end else begin
            do_end = 1'b1;
            if (mpos_r >= REPLY_LEN && mflags_r[0]) begin
              kind_nxt  = KIND_REPLY;
              phase_nxt = PH_STATUS;
            end else begin
              kind_nxt  = (mpos_r == GET_LEN && mflags_r[1]) ? KIND_GET : KIND_OTHER;
              phase_nxt = PH_PATH;
            end
          end
        end
        PH_STATUS: begin
          sec = SEC_STATUS;
          if (c != CH_LF) do_store = 1'b1;
          else begin
            do_end    = 1'b1;
            phase_nxt = PH_LINE_START;
          end
        end
        PH_PATH: begin
          sec = SEC_PATH;
          if (c != CH_SP) do_store = 1'b1;
          else begin
            do_end    = 1'b1;
            phase_nxt = PH_VERSION;
          end
        end
        PH_VERSION: begin
          sec = SEC_VERSION;
          if (c != CH_LF) do_store = 1'b1;
          else begin
            do_end    = 1'b1;
            phase_nxt = PH_LINE_START;
          end
        end
        PH_KEY: begin
          sec = SEC_KEY;
          if (c != CH_COLON) do_store = 1'b1;
          else begin
            do_end = 1'b1;
            if (mpos_r == CLEN_LEN && mflags_r[2]) begin
              // a new length header restarts the value
              end_islen = 1'b1;
              acc_nxt   = '0;
              done_nxt  = 1'b0;
              phase_nxt = PH_LEN_SEP;
            end else begin
              phase_nxt = PH_HDR_SEP;
            end
          end
        end
        PH_LEN_SEP: begin
          sec = SEC_LENGTH;
          if (c != CH_SP) begin
            phase_nxt = PH_LEN;
            do_digit  = 1'b1;
            do_store  = 1'b1;
          end
        end
        PH_LEN: begin
          sec = SEC_LENGTH;
          if (c == CH_LF) begin
            do_end    = 1'b1;
            phase_nxt = PH_LINE_START;
          end else begin
            do_digit = 1'b1;
            do_store = 1'b1;
          end
        end
        PH_HDR_SEP: begin
          sec = SEC_VALUE;
          if (c != CH_SP) begin
            phase_nxt = PH_HDR_VAL;
            do_store  = 1'b1;
          end
        end
        PH_HDR_VAL: begin
          sec = SEC_VALUE;
          if (c != CH_LF) do_store = 1'b1;
          else begin
            do_end    = 1'b1;
            phase_nxt = PH_LINE_START;
          end
        end
        PH_LINE_START: begin
          sec = SEC_KEY;
          if (c != CH_LF) begin
            phase_nxt = PH_KEY;
            do_store  = 1'b1;
          end else begin
            // blank line: headers done
            phase_nxt  = PH_BODY_SEP;
            body_nxt   = '0;
            tc_nxt     = '0;
            drop_nxt   = 1'b0;
            mpos_nxt   = '0;
            mflags_nxt = 3'b111;
            emit       = 1'b1;
            ev         = EV_HDR_END;
            ev_sec     = SEC_BODY;
            ev_last    = (kind_r == KIND_GET);
          end
        end
        PH_BODY_SEP, PH_BODY: begin
          if (phase_r == PH_BODY || c != CH_LF) begin
            phase_nxt = PH_BODY;
            body_nxt  = (body_r < COUNT_MAX) ? body_r + 1'b1 : body_r;
            fin = (kind_r != KIND_GET) && (CMP_W'(body_r) < CMP_W'(acc_r)) &&
                  (CMP_W'(body_nxt) == CMP_W'(acc_r));
            ev_sec = SEC_BODY;
            if (room) begin
              tc_nxt  = tc_r + 1'b1;
              emit    = 1'b1;
              ev      = EV_DATA;
              ev_byte = c;
              ev_last = fin;
            end else begin
              drop_nxt = 1'b1;
              if (fin) begin
                // final body byte lost: report as a truncated token end
                emit     = 1'b1;
                ev       = EV_TOKEN_END;
                ev_trunc = 1'b1;
                ev_last  = 1'b1;
              end
            end
            if (fin) begin
              tc_nxt     = '0;
              drop_nxt   = 1'b0;
              mpos_nxt   = '0;
              mflags_nxt = 3'b111;
            end
          end
        end
        default: ;
      endcase

      if (do_digit && !done_r) begin
        if (c >= CH_0 && c <= CH_9) begin
          acc_nxt = (acc_mul > 20'(LEN_SAT)) ? LEN_SAT : acc_mul[LEN_W-1:0];
        end else begin
          done_nxt = 1'b1;
        end
      end

      if (do_store) begin
        mpos_nxt   = mpos_upd;
        mflags_nxt = mflags_upd;
        ev_sec     = sec;
        if (room) begin
          tc_nxt  = tc_r + 1'b1;
          emit    = 1'b1;
          ev      = EV_DATA;
          ev_byte = c;
        end else begin
          drop_nxt = 1'b1;
        end
      end

      if (do_end) begin
        emit       = 1'b1;
        ev         = EV_TOKEN_END;
        ev_sec     = sec;
        ev_islen   = end_islen;
        ev_trunc   = drop_r;
        tc_nxt     = '0;
        drop_nxt   = 1'b0;
        mpos_nxt   = '0;
        mflags_nxt = 3'b111;
      end
    end
  end

  assign res_valid   = adv && emit;
  assign res.ev      = ev;
  assign res.section = ev_sec;
  assign res.data    = ev_byte;
  assign res.kind    = kind_nxt;
  assign res.is_len  = ev_islen;
  assign res.clen    = acc_nxt;
  assign res.trunc   = ev_trunc;
  assign res.last    = ev_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      max_len_r  <= MAX_TOKEN_RESET;
      phase_r    <= PH_METHOD;
      kind_r     <= KIND_UNKNOWN;
      tc_r       <= '0;
      mpos_r     <= '0;
      mflags_r   <= 3'b111;
      acc_r      <= '0;
      done_r     <= 1'b0;
      body_r     <= '0;
      drop_r     <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
      if (adv) begin
        phase_r  <= phase_nxt;
        kind_r   <= kind_nxt;
        tc_r     <= tc_nxt;
        mpos_r   <= mpos_nxt;
        mflags_r <= mflags_nxt;
        acc_r    <= acc_nxt;
        done_r   <= done_nxt;
        body_r   <= body_nxt;
        drop_r   <= drop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_req_r  <= in_req;
      in_byte_r <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/hhsp_outreg.sv =====
module hhsp_outreg
  import hhsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  res_t        res,
  output logic        slot_free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic out_valid_r;
  res_t res_r;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.ev;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {1'b0, res_r.trunc, res_r.clen, res_r.is_len, res_r.kind,
                       res_r.data, res_r.section};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== hw/rtl/http_header_stream_parser.sv =====
// HTTP/1.1 message header parser, one byte per transaction.
// Input channel: in_tdata carries a received byte, in_tuser set means the
// connection closed and the parse state returns to the start line.
// Result channel: at most one result per input byte. out_tuser gives the
// event (stored byte, token end, blank line ending the headers), out_tlast
// marks a complete message (GET at its blank line, else the last counted
// body byte), out_tdata the section, byte and parse status.
// Config channel: cfg_data sets the token length limit (reset value 200);
// write it only while no byte is in flight.
// Each byte passes the input register and then the output register on its way to the output port.
// Throughput: one byte per cycle while the receiver accepts results; the per-byte state update and pattern
// compares sit between the input register and the result register.
// Reset (rst_n low, synchronous) clears the parser and the valid bits of both registers.
// When the receiver stalls, the result is held in the output register and
// in_tready drops once the input register is also full.
module http_header_stream_parser
  import hhsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] section, [10:3] out_byte, [12:11] message_kind,
                                  // [13] is_length_header, [29:14] length_value,
                                  // [30] truncated, [31] zero
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic slot_free;
  logic res_valid;
  res_t res;

  assign cfg_ready = 1'b1;

  hhsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_req    (in_tuser[0]),
    .in_byte   (in_tdata),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  hhsp_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/hhsp_checker.sv =====
module hhsp_checker
  import hhsp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_byte_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_DATA |-> out_tdata[10:3] == 8'h00)
    else $error("nonzero byte on non-data event");

  a_hdr_end_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_HDR_END |-> out_tdata[2:0] == SEC_BODY &&
    out_tdata[30] == 1'b0 && out_tdata[13] == 1'b0)
    else $error("bad header end result");

  a_data_untrunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == EV_DATA |-> out_tdata[30] == 1'b0 &&
    out_tdata[13] == 1'b0)
    else $error("flags set on data byte");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser == EV_HDR_END |-> out_tdata[12:11] == KIND_GET)
    else $error("completion at blank line for non-GET");

endmodule

bind http_header_stream_parser hhsp_checker u_hhsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
